// ----- sv/frfifo_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and result type for the framed record FIFO.
// No dependencies; every other file except frfifo_out_if imports this package.
package frfifo_pkg;

	localparam int RING_BYTES    = 65536;
	localparam int RING_AW       = $clog2(RING_BYTES);
	localparam int USED_W        = RING_AW + 1;
	localparam int LEN_W         = 12;
	localparam int PAYLOAD_LIMIT = 4064;
	localparam int HDR_BYTES     = 4;
	localparam int HDR_W         = 8 * HDR_BYTES;

	localparam logic [1:0] OP_OPEN    = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       last;
		logic [1:0] status;
		logic       dropped_old;
	} frfifo_res_t;

	// Clamp a stored header to the payload limit.
	function automatic logic [LEN_W-1:0] clamp_len(input logic [HDR_W-1:0] v);
		if (v > HDR_W'(PAYLOAD_LIMIT)) begin
			return LEN_W'(PAYLOAD_LIMIT);
		end
		return v[LEN_W-1:0];
	endfunction

endpackage

// ----- sv/frfifo_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one command beat.
// Depends on frfifo_pkg for field widths.
interface frfifo_in_if import frfifo_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	logic [LEN_W-1:0] length;
	logic [7:0]       data;

	modport source (output valid, op, length, data, input ready);
	modport sink (input valid, op, length, data, output ready);
endinterface

// ----- sv/frfifo_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one result beat.
// No package dependency.
interface frfifo_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       last;
	logic [1:0] status;
	logic       dropped_old;

	modport source (output valid, byte_out, last, status, dropped_old, input ready);
	modport sink (input valid, byte_out, last, status, dropped_old, output ready);
endinterface

// ----- sv/framed_record_fifo_drop_oldest_top.sv -----
`timescale 1ns / 1ps
// Framed record FIFO with drop-oldest admission: ring memory, read store, sequencer.
// Depends on frfifo_pkg, frfifo_in_if and frfifo_out_if.
//
//   channel   dir   beat contents                       handshake
//   in_ch     in    op, length, data                    valid/ready
//   out_ch    out   byte_out, last, status, dropped_old valid/ready
//
// Payload beats and rejects go straight to the result state; reads of a staged record
// pass through a byte-read state first. An accepted open walks the header of each dropped
// record on the single ring read port, then writes its own header; a read that stages a
// record first copies it, one ring byte copied per cycle. One item is in work at a time.
// Reset clears all pointers and counts; memory contents stay undefined.
// in_ch.ready drops while an item is in work; a stalled out_ch holds its beat.
module framed_record_fifo_drop_oldest_top import frfifo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	frfifo_in_if.sink   in_ch,
	frfifo_out_if.source out_ch
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_CHECK    = 9'b000000010,
		S_TAKE_HDR = 9'b000000100,
		S_TAKE_N   = 9'b000001000,
		S_COPY     = 9'b000010000,
		S_RSET     = 9'b000100000,
		S_RBYTE    = 9'b001000000,
		S_HDRW     = 9'b010000000,
		S_FIN      = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [RING_AW-1:0] head_q, commit_q, write_q;
	logic [USED_W-1:0]  used_q;
	logic [LEN_W-1:0]   open_rem_q, stg_len_q, stg_pos_q, len_q, cnt_q, wk_q;
	logic [HDR_W-1:0]   hdr_q;
	logic               rv_q, rd_mode_q, out_vld_q;
	frfifo_res_t        res_q, out_q;

	logic [7:0] ring_mem [RING_BYTES];
	logic [7:0] rs_mem [PAYLOAD_LIMIT];
	logic [7:0] ring_rd_q, rs_rd_q;

	logic               in_acc, out_free, ring_issue, ring_we, rs_we;
	logic [7:0]         ring_wdata, hdr_byte;
	logic [LEN_W-1:0]   rs_raddr, take_n;
	logic [USED_W-1:0]  free_w, need_w;
	logic [LEN_W:0]     pos_next;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_vld_q || out_ch.ready;

	assign ring_issue = ((state_q == S_TAKE_HDR) && (cnt_q < LEN_W'(HDR_BYTES)))
		|| ((state_q == S_COPY) && (cnt_q < stg_len_q));
	assign free_w   = USED_W'(RING_BYTES) - used_q;
	assign need_w   = USED_W'(HDR_BYTES) + USED_W'(len_q);
	assign take_n   = clamp_len(hdr_q);
	assign pos_next = {1'b0, stg_pos_q} + 1'b1;
	assign rs_raddr = (stg_pos_q >= LEN_W'(PAYLOAD_LIMIT)) ? LEN_W'(PAYLOAD_LIMIT - 1)
		: stg_pos_q;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: hdr_byte = len_q[7:0];
			2'd1: hdr_byte = 8'(len_q >> 8);
			default: hdr_byte = 8'd0;
		endcase
	end

	assign ring_we = (in_acc && (in_ch.op == OP_PAYLOAD) && (open_rem_q != '0))
		|| (state_q == S_HDRW);
	assign ring_wdata = (state_q == S_HDRW) ? hdr_byte : in_ch.data;
	assign rs_we = (state_q == S_COPY) && rv_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[write_q] <= ring_wdata;
		end
		ring_rd_q <= ring_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[wk_q] <= ring_rd_q;
		end
		rs_rd_q <= rs_mem[rs_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			commit_q   <= '0;
			write_q    <= '0;
			used_q     <= '0;
			open_rem_q <= '0;
			stg_len_q  <= '0;
			stg_pos_q  <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			wk_q       <= '0;
			hdr_q      <= '0;
			rv_q       <= 1'b0;
			rd_mode_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			rv_q <= ring_issue;
			if (ring_issue) begin
				head_q <= head_q + 1'b1;
				used_q <= used_q - 1'b1;
				cnt_q  <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_q   <= '0;
						state_q <= S_FIN;
						cnt_q   <= '0;
						wk_q    <= '0;
						unique case (in_ch.op)
							OP_OPEN: begin
								if ((in_ch.length == '0) || (open_rem_q != '0)
									|| (in_ch.length > LEN_W'(PAYLOAD_LIMIT))) begin
									res_q.status <= ST_INVALID;
								end else begin
									len_q   <= in_ch.length;
									state_q <= S_CHECK;
								end
							end
							OP_PAYLOAD: begin
								if (open_rem_q == '0) begin
									res_q.status <= ST_INVALID;
								end else begin
									write_q    <= write_q + 1'b1;
									used_q     <= used_q + 1'b1;
									open_rem_q <= open_rem_q - 1'b1;
									if (open_rem_q == LEN_W'(1)) begin
										commit_q <= write_q + 1'b1;
									end
								end
							end
							OP_READ: begin
								if (stg_len_q != '0) begin
									state_q <= S_RBYTE;
								end else if (head_q != commit_q) begin
									rd_mode_q <= 1'b1;
									state_q   <= S_TAKE_HDR;
								end else begin
									res_q.status <= ST_EMPTY;
								end
							end
							default: res_q.status <= ST_INVALID;
						endcase
					end
				end
				S_CHECK: begin
					cnt_q <= '0;
					wk_q  <= '0;
					if ((free_w < need_w) && (head_q != commit_q)) begin
						rd_mode_q <= 1'b0;
						state_q   <= S_TAKE_HDR;
					end else begin
						state_q <= S_HDRW;
					end
				end
				S_TAKE_HDR: begin
					if (rv_q) begin
						hdr_q <= {ring_rd_q, hdr_q[HDR_W-1:8]};
						wk_q  <= wk_q + 1'b1;
						if (wk_q == LEN_W'(HDR_BYTES - 1)) begin
							state_q <= S_TAKE_N;
						end
					end
				end
				S_TAKE_N: begin
					cnt_q <= '0;
					wk_q  <= '0;
					if (rd_mode_q) begin
						if (take_n == '0) begin
							res_q.status <= ST_EMPTY;
							state_q      <= S_FIN;
						end else begin
							stg_len_q <= take_n;
							stg_pos_q <= '0;
							state_q   <= S_COPY;
						end
					end else begin
						head_q            <= head_q + RING_AW'(take_n);
						used_q            <= used_q - USED_W'(take_n);
						res_q.dropped_old <= 1'b1;
						state_q           <= S_CHECK;
					end
				end
				S_COPY: begin
					if (rv_q) begin
						wk_q <= wk_q + 1'b1;
						if (wk_q == stg_len_q - 1'b1) begin
							state_q <= S_RSET;
						end
					end
				end
				S_RSET: state_q <= S_RBYTE;
				S_RBYTE: begin
					res_q.byte_out <= rs_rd_q;
					if (pos_next >= {1'b0, stg_len_q}) begin
						res_q.last <= 1'b1;
						stg_len_q  <= '0;
						stg_pos_q  <= '0;
					end else begin
						stg_pos_q <= pos_next[LEN_W-1:0];
					end
					state_q <= S_FIN;
				end
				S_HDRW: begin
					write_q <= write_q + 1'b1;
					used_q  <= used_q + 1'b1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == LEN_W'(HDR_BYTES - 1)) begin
						open_rem_q <= len_q;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_vld_q <= 1'b1;
			out_q     <= res_q;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.byte_out    = out_q.byte_out;
	assign out_ch.last        = out_q.last;
	assign out_ch.status      = out_q.status;
	assign out_ch.dropped_old = out_q.dropped_old;

endmodule

// ----- sv/frfifo_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the framed record FIFO, bound to its top level.
// Depends on frfifo_pkg for status codes.
module frfifo_checker import frfifo_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic       last,
	input logic [1:0] status,
	input logic       dropped_old
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status))
		else $error("result beat changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while one is in work");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> status == ST_OK)
		else $error("last marked on a failed beat");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (byte_out == 8'd0) && !dropped_old)
		else $error("failed beat carries data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_EMPTY) || (status == ST_INVALID))
		else $error("undefined status code");

endmodule

bind framed_record_fifo_drop_oldest_top frfifo_checker u_frfifo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.byte_out    (out_ch.byte_out),
	.last        (out_ch.last),
	.status      (out_ch.status),
	.dropped_old (out_ch.dropped_old)
);
